FILE: design/pqa_pkg.sv
// Package: shared types, constants and the cosine table of the pseudo-QMF analysis unit
`timescale 1ns / 1ps

package pqa_pkg;

   localparam int HISTORY_LEN = 512;
   localparam int BANDS       = 32;
   localparam int ROM_LEN     = 128;
   localparam int CMD_DEPTH   = 4;

   localparam logic [31:0] BAND0_COEF = 32'h07ff_ffff;
   localparam logic [31:0] ROT_SIN    = 32'd105372028;
   localparam logic [31:0] ROT_COS    = 32'd2144896908;
   localparam logic [31:0] UNITY      = 32'h7fff_ffff;
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic        operation;
      logic [2:0]  channel;
      logic [31:0] sample;
      logic [8:0]  coef_index;
      logic [31:0] coef_value;
   } pqa_req_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic [4:0]  band_index;
      logic [31:0] band_value;
      logic        last_band;
   } pqa_rsp_type;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   ch;
      logic [8:0]   idx;
      logic [31:0]  data;
   } pqa_cmd_type;

   typedef struct packed {
      logic clearing;
   } pqa_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WAIT_OUT,
      ST_FOLD,
      ST_FOLD_DRAIN,
      ST_BAND,
      ST_BAND_DRAIN
   } pqa_state_type;

   typedef struct packed {
      logic       band;
      logic [4:0] idx;
      logic       first;
      logic       last;
   } pqa_tag_type;

   typedef logic [ROM_LEN-1:0][31:0] rom_type;

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] p;
      logic [63:0]        u;
      p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      u = 64'(p) + ROUND_HALF;
      return u[63:32];
   endfunction

   function automatic logic [31:0] asr3(input logic [31:0] v);
      return {{3{v[31]}}, v[31:3]};
   endfunction

   function automatic rom_type build_rom();
      rom_type          r;
      logic [16:0][31:0] cv;
      logic [16:0][31:0] sv;
      logic [31:0]      ts;
      logic [31:0]      tc;
      int               i;
      sv[0] = 32'd0;
      cv[0] = UNITY;
      for (i = 1; i <= 16; i++) begin
         ts    = mul32(cv[i-1], ROT_SIN) + mul32(sv[i-1], ROT_COS);
         tc    = mul32(cv[i-1], ROT_COS) - mul32(sv[i-1], ROT_SIN);
         sv[i] = {ts[30:0], 1'b0};
         cv[i] = {tc[30:0], 1'b0};
      end
      for (i = 0; i < 16; i++) begin
         r[i]       = asr3(cv[i]);
         r[i + 16]  = asr3(sv[16 - i]);
         r[i + 32]  = asr3(32'd0 - sv[i]);
         r[i + 48]  = asr3(32'd0 - cv[16 - i]);
         r[i + 64]  = asr3(32'd0 - cv[i]);
         r[i + 80]  = asr3(32'd0 - sv[16 - i]);
         r[i + 96]  = asr3(sv[i]);
         r[i + 112] = asr3(cv[16 - i]);
      end
      return r;
   endfunction

   localparam rom_type COS_ROM = build_rom();

endpackage

FILE: design/pqa_queue.sv
// Short first-in first-out queue of packed entries
`timescale 1ns / 1ps

module pqa_queue #(
   parameter type ENTRY_type = logic,
   parameter int  DEPTH      = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  ENTRY_type push_data,
   output logic      full,
   input  logic      pop,
   output ENTRY_type pop_data,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ENTRY_type         entry_ff [DEPTH];
   logic [PW-1:0]     wr_ff;
   logic [PW-1:0]     wr_in;
   logic [PW-1:0]     rd_ff;
   logic [PW-1:0]     rd_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: design/pqa_front.sv
// Front end: accept request transfers, drop samples of absent channels, stage commands
`timescale 1ns / 1ps

module pqa_front #(
   parameter int CHANNELS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  pqa_pkg::pqa_req_type    req_data,
   output logic                    req_full,
   input  pqa_pkg::pqa_status_type status,
   input  logic                    cmd_full,
   output logic                    cmd_push,
   output pqa_pkg::pqa_cmd_type    cmd_data
);

   logic                 valid_ff;
   logic                 valid_in;
   pqa_pkg::pqa_cmd_type cmd_ff;
   pqa_pkg::pqa_cmd_type cmd_in;
   logic                 accept;
   logic                 keep;

   assign req_full = status.clearing || (valid_ff && cmd_full);
   assign accept   = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;
   assign cmd_data = cmd_ff;

   always_comb begin
      cmd_in.kind = pqa_pkg::cmd_kind_type'(req_data.operation);
      cmd_in.ch   = req_data.channel;
      cmd_in.idx  = req_data.coef_index;
      cmd_in.data = (cmd_in.kind == pqa_pkg::CMD_LOAD) ? req_data.coef_value : req_data.sample;
      keep        = (cmd_in.kind == pqa_pkg::CMD_LOAD) || (32'(req_data.channel) < CHANNELS);
      valid_in    = valid_ff;
      if (accept) begin
         valid_in = keep;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

FILE: design/pqa_back.sv
// Back end: history and window memories, fold and cosine passes on one shared multiplier
`timescale 1ns / 1ps

module pqa_back #(
   parameter int CHANNELS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_empty,
   input  pqa_pkg::pqa_cmd_type    cmd_data,
   output logic                    cmd_pop,
   input  logic                    out_empty,
   output logic                    rsp_push,
   output pqa_pkg::pqa_rsp_type    rsp_entry,
   output pqa_pkg::pqa_status_type status
);

   localparam int HIST_DEPTH = CHANNELS * pqa_pkg::HISTORY_LEN;
   localparam int HA_W       = $clog2(HIST_DEPTH);
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   pqa_pkg::pqa_state_type state_ff;
   pqa_pkg::pqa_state_type state_in;

   logic [31:0]        hist_mem [HIST_DEPTH];
   logic [31:0]        win_mem [pqa_pkg::HISTORY_LEN];
   logic [31:0]        acc_ff [pqa_pkg::BANDS];
   logic [8:0]         ptr_ff [CHANNELS];
   logic [9:0]         cnt_ff;
   logic [HA_W-1:0]    clr_ff;
   logic [2:0]         blk_ch_ff;
   logic [8:0]         start_ff;

   logic [31:0]        hist_rd_ff;
   logic [31:0]        win_rd_ff;
   logic [31:0]        opa_ff;
   logic [31:0]        opb_ff;
   logic               v1_ff;
   logic               v2_ff;
   pqa_pkg::pqa_tag_type tag1_ff;
   pqa_pkg::pqa_tag_type tag2_ff;
   pqa_pkg::pqa_tag_type tag_in;
   logic signed [63:0] prod_ff;
   logic [31:0]        sum_ff;
   pqa_pkg::pqa_rsp_type res_ff;
   logic               res_valid_ff;

   logic               hist_we;
   logic [HA_W-1:0]    hist_wa;
   logic [31:0]        hist_wd;
   logic               win_we;
   logic               issue_fold;
   logic               issue_band;
   logic               acc_clear;
   logic               take_sample;
   logic [CH_W-1:0]    ch_sel;
   logic [8:0]         ptr_next;
   logic [HA_W-1:0]    fold_ra;
   logic [4:0]         band_b;
   logic [4:0]         band_j;
   logic [10:0]        rom_prod;
   logic [31:0]        coef;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic [63:0]        rnd;
   logic [31:0]        term;
   logic [31:0]        band_sum;

   assign ch_sel      = cmd_data.ch[CH_W-1:0];
   assign ptr_next    = ptr_ff[ch_sel] + 9'd1;
   assign take_sample = cmd_pop && (cmd_data.kind == pqa_pkg::CMD_SAMPLE);
   assign fold_ra     = HA_W'({blk_ch_ff, 9'(start_ff + cnt_ff[8:0])});
   assign band_b      = cnt_ff[9:5];
   assign band_j      = cnt_ff[4:0];
   assign rom_prod    = 11'(band_b) * 11'({band_j, 1'b1});
   assign coef        = (band_b == 5'd0) ? pqa_pkg::BAND0_COEF : pqa_pkg::COS_ROM[rom_prod[6:0]];
   assign status.clearing = (state_ff == pqa_pkg::ST_CLEAR);
   assign rsp_push    = res_valid_ff;
   assign rsp_entry   = res_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pqa_pkg::ST_CLEAR: begin
            if (clr_ff == HA_W'(HIST_DEPTH - 1)) state_in = pqa_pkg::ST_IDLE;
         end
         pqa_pkg::ST_IDLE: begin
            if (take_sample && (ptr_next[4:0] == 5'd0)) state_in = pqa_pkg::ST_WAIT_OUT;
         end
         pqa_pkg::ST_WAIT_OUT: begin
            if (out_empty) state_in = pqa_pkg::ST_FOLD;
         end
         pqa_pkg::ST_FOLD: begin
            if (cnt_ff[8:0] == 9'd511) state_in = pqa_pkg::ST_FOLD_DRAIN;
         end
         pqa_pkg::ST_FOLD_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = pqa_pkg::ST_BAND;
         end
         pqa_pkg::ST_BAND: begin
            if (cnt_ff == 10'd1023) state_in = pqa_pkg::ST_BAND_DRAIN;
         end
         pqa_pkg::ST_BAND_DRAIN: begin
            if (!v1_ff && !v2_ff && !res_valid_ff) state_in = pqa_pkg::ST_IDLE;
         end
         default: state_in = pqa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      hist_we    = 1'b0;
      hist_wa    = HA_W'({cmd_data.ch, ptr_ff[ch_sel]});
      hist_wd    = cmd_data.data;
      win_we     = 1'b0;
      issue_fold = 1'b0;
      issue_band = 1'b0;
      acc_clear  = 1'b0;
      case (state_ff)
         pqa_pkg::ST_CLEAR: begin
            hist_we = 1'b1;
            hist_wa = clr_ff;
            hist_wd = 32'd0;
         end
         pqa_pkg::ST_IDLE: begin
            cmd_pop = !cmd_empty;
            hist_we = take_sample;
            win_we  = cmd_pop && (cmd_data.kind == pqa_pkg::CMD_LOAD);
         end
         pqa_pkg::ST_WAIT_OUT: acc_clear  = out_empty;
         pqa_pkg::ST_FOLD:     issue_fold = 1'b1;
         pqa_pkg::ST_BAND:     issue_band = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      tag_in.band  = issue_band;
      tag_in.idx   = band_b;
      tag_in.first = (band_j == 5'd0);
      tag_in.last  = (band_j == 5'd31);
      if (issue_fold) begin
         tag_in.idx = cnt_ff[5] ^ cnt_ff[4] ? {~cnt_ff[4], cnt_ff[3:0]}
                                             : 5'd31 - {~cnt_ff[4], cnt_ff[3:0]};
      end
   end

   assign mul_a    = tag1_ff.band ? opa_ff : hist_rd_ff;
   assign mul_b    = tag1_ff.band ? opb_ff : win_rd_ff;
   assign rnd      = 64'(prod_ff) + pqa_pkg::ROUND_HALF;
   assign term     = rnd[63:32];
   assign band_sum = (tag2_ff.first ? 32'd0 : sum_ff) + term;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqa_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         res_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) ptr_ff[c] <= '0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= issue_fold || issue_band;
         v2_ff        <= v1_ff;
         res_valid_ff <= v2_ff && tag2_ff.band && tag2_ff.last;
         if (status.clearing) clr_ff <= clr_ff + HA_W'(1);
         if (acc_clear || (state_ff == pqa_pkg::ST_FOLD_DRAIN)) begin
            cnt_ff <= '0;
         end else if (issue_fold || issue_band) begin
            cnt_ff <= cnt_ff + 10'd1;
         end
         if (take_sample) ptr_ff[ch_sel] <= ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         blk_ch_ff <= cmd_data.ch;
         start_ff  <= ptr_next;
      end
      if (hist_we) hist_mem[hist_wa] <= hist_wd;
      hist_rd_ff <= hist_mem[fold_ra];
      if (win_we) win_mem[cmd_data.idx] <= cmd_data.data;
      win_rd_ff <= win_mem[cnt_ff[8:0]];
      opa_ff    <= acc_ff[band_j];
      opb_ff    <= coef;
      tag1_ff   <= tag_in;
      tag2_ff   <= tag1_ff;
      prod_ff   <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (acc_clear) begin
         for (int m = 0; m < pqa_pkg::BANDS; m++) acc_ff[m] <= 32'd0;
      end else if (v2_ff && !tag2_ff.band) begin
         acc_ff[tag2_ff.idx] <= acc_ff[tag2_ff.idx] + term;
      end
      if (v2_ff && tag2_ff.band) begin
         sum_ff <= band_sum;
         res_ff.out_channel <= blk_ch_ff;
         res_ff.band_index  <= tag2_ff.idx;
         res_ff.band_value  <= tag2_ff.idx[1] ? 32'd0 - band_sum : band_sum;
         res_ff.last_band   <= (tag2_ff.idx == 5'd31);
      end
   end

endmodule

FILE: design/pseudo_qmf_analysis_32band_unit.sv
// Top level: 32-band pseudo-QMF analysis unit
`timescale 1ns / 1ps

// Load items write one window tap and sample items enter their channel's 512-word history;
// both pass through a four-entry command queue into the back end. The 32nd sample of a
// channel starts a block of 512 fold multiplies, 1024 cosine multiplies and pipeline drains,
// all on a single 32x32 multiplier, during which the back end takes no new items. A block
// begins only once the 32-entry result queue is empty. After reset a clearing pass zeroes
// the history, with req_full held high.

module pseudo_qmf_analysis_32band_unit #(
   parameter int CHANNELS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  pqa_pkg::pqa_req_type req_data,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output pqa_pkg::pqa_rsp_type rsp_data
);

   pqa_pkg::pqa_status_type status;
   pqa_pkg::pqa_cmd_type    front_cmd;
   pqa_pkg::pqa_cmd_type    back_cmd;
   pqa_pkg::pqa_rsp_type    rsp_entry;
   logic                    front_push;
   logic                    cmd_full;
   logic                    cmd_empty;
   logic                    cmd_pop;
   logic                    rsp_push;
   logic                    rsp_full;

   pqa_front #(.CHANNELS(CHANNELS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .status   (status),
      .cmd_full (cmd_full),
      .cmd_push (front_push),
      .cmd_data (front_cmd)
   );

   pqa_queue #(.ENTRY_type(pqa_pkg::pqa_cmd_type), .DEPTH(pqa_pkg::CMD_DEPTH)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   pqa_back #(.CHANNELS(CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .out_empty (rsp_empty && !rsp_full),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_entry),
      .status    (status)
   );

   pqa_queue #(.ENTRY_type(pqa_pkg::pqa_rsp_type), .DEPTH(pqa_pkg::BANDS)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_entry),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

FILE: design/pqa_checker.sv
// Checker: port-level assertions for the pseudo-QMF analysis unit, with its bind
`timescale 1ns / 1ps

module pqa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input pqa_pkg::pqa_rsp_type rsp_data
);

   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && req_full)
      else $error("results or input space visible straight after reset");

   a_last_is_31: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last_band) |-> (rsp_data.band_index == 5'd31))
      else $error("last_band on a band other than 31");

   a_31_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && (rsp_data.band_index == 5'd31)) |-> rsp_data.last_band)
      else $error("band 31 without last_band");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before its transfer");

endmodule

bind pseudo_qmf_analysis_32band_unit pqa_checker u_pqa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
